// ===== hdl/mtdb_pkg.sv =====
// mtdb_pkg: shared types, constants and the log2 table for magnitude_to_db_limited
// no dependencies

package mtdb_pkg;

    localparam int IN_WIDTH   = 32;
    localparam int FRAC_IN    = 16;
    localparam int LOG_DEPTH  = 256;
    localparam int LOG_BITS   = $clog2(LOG_DEPTH);
    localparam int POS_W      = $clog2(IN_WIDTH);
    localparam int EXP_W      = POS_W + 1;
    localparam int Q_FRAC     = 30;
    localparam int REM_W      = Q_FRAC - LOG_BITS;
    localparam int DIFF_W     = Q_FRAC + 1 - LOG_BITS;
    localparam int ROM_W      = Q_FRAC + 1;
    localparam int DB_W       = 18;
    localparam int LIMIT_W    = 18;
    localparam int K_W        = 28;
    localparam int PROD_W     = 64;
    localparam int ROUND_SH   = 46;
    localparam int CFG_IDX_W  = 3;

    // 20*log10(2) in q24
    localparam logic signed [K_W-1:0] DB_PER_OCTAVE = 28'sd101008905;

    localparam logic signed [DB_W-1:0]    DB_MIN        = -18'sd131072;
    localparam logic signed [DB_W-1:0]    DB_MAX        = 18'sd131071;
    localparam logic signed [LIMIT_W-1:0] DEFAULT_FLOOR = -18'sd81920;
    localparam logic signed [LIMIT_W-1:0] DEFAULT_CEIL  = 18'sd81920;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_SYM  = 2'd1,
        MODE_SEP  = 2'd2,
        MODE_RSVD = 2'd3
    } limit_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_MODE   = 3'd0,
        REG_LOWER_ENABLE = 3'd1,
        REG_UPPER_ENABLE = 3'd2,
        REG_LOWER_LIMIT  = 3'd3,
        REG_UPPER_LIMIT  = 3'd4
    } cfg_index_t;

    typedef logic [ROM_W-1:0] log_rom_t [0:LOG_DEPTH];

    // log2(1 + i/LOG_DEPTH) in q30 by repeated squaring, evaluated at elaboration
    function automatic log_rom_t build_log_rom();
        log_rom_t rom;
        logic [63:0] y;
        logic [Q_FRAC-1:0] r;
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            y = (64'(LOG_DEPTH + i) << Q_FRAC) / LOG_DEPTH;
            r = '0;
            for (int b = Q_FRAC - 1; b >= 0; b--)
            begin
                y = (y * y) >> Q_FRAC;
                if (y >= (64'd1 << (Q_FRAC + 1)))
                begin
                    r[b] = 1'b1;
                    y = y >> 1;
                end
            end
            rom[i] = {1'b0, r};
        end
        rom[LOG_DEPTH] = ROM_W'(64'd1 << Q_FRAC);
        return rom;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ===== hdl/magnitude_to_db_limited.sv =====
// magnitude_to_db_limited: 20*log10(|x|) in q10.8 dB with configurable clamps
// depends on mtdb_pkg (constants, log2 table)

// Takes one signed q16.16 sample per clock when start is high (busy is always
// low) and returns one q10.8 dB item on db_value, marked by a one-cycle done
// strobe at the end of the nine-stage pipeline:
// abs, leading-one normalize, table read, interpolation multiply, interpolation
// add, scale multiplies, product sum, rounding, clamp. The receiver cannot stall
// the output. Limit registers must only be written while no item is in flight.

module magnitude_to_db_limited (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [mtdb_pkg::IN_WIDTH-1:0]   magnitude,
    output logic                                   done,
    output logic signed [mtdb_pkg::DB_W-1:0]       db_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mtdb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mtdb_pkg::LIMIT_W-1:0]           cfg_data
);
    import mtdb_pkg::*;

    // configuration
    limit_mode_t                limit_mode_reg;
    logic                       lower_enable_reg;
    logic                       upper_enable_reg;
    logic signed [LIMIT_W-1:0]  lower_limit_reg;
    logic signed [LIMIT_W-1:0]  upper_limit_reg;

    // pipeline valid bits, one per stage
    logic [8:0] valid_reg;

    // stage 1
    logic [IN_WIDTH-1:0]            abs1_reg;
    // stage 2
    logic [Q_FRAC-1:0]              frac2_reg;
    logic [POS_W-1:0]               pos2_reg;
    logic                           zero2_reg;
    // stage 3
    logic [ROM_W-1:0]               t0_3_reg;
    logic [DIFF_W-1:0]              diff3_reg;
    logic [Q_FRAC-1:0]              rem3_reg;
    logic [POS_W-1:0]               pos3_reg;
    logic                           zero3_reg;
    // stage 4
    logic [ROM_W-1:0]               t0_4_reg;
    logic [DIFF_W+Q_FRAC-1:0]       iprod4_reg;
    logic [POS_W-1:0]               pos4_reg;
    logic                           zero4_reg;
    // stage 5
    logic [ROM_W-1:0]               frac5_reg;
    logic [POS_W-1:0]               pos5_reg;
    logic                           zero5_reg;
    // stage 6
    logic [ROM_W+K_W-1:0]           fprod6_reg;
    logic signed [EXP_W+K_W-1:0]    eprod6_reg;
    logic                           zero6_reg;
    // stage 7
    logic signed [PROD_W-1:0]       prod7_reg;
    logic                           zero7_reg;
    // stage 8
    logic [DB_W-1:0]                mag8_reg;
    logic                           neg8_reg;
    logic                           zero8_reg;
    // stage 9
    logic signed [DB_W-1:0]         db9_reg;

    // combinational
    logic [IN_WIDTH-1:0]            abs_next;
    logic [POS_W-1:0]               pos_next;
    logic [IN_WIDTH+Q_FRAC-1:0]     norm;
    logic [LOG_BITS-1:0]            idx;
    logic [ROM_W-1:0]               t0_val;
    logic [ROM_W-1:0]               t1_val;
    logic [ROM_W-1:0]               frac_next;
    logic signed [EXP_W-1:0]        exp_val;
    logic signed [PROD_W-1:0]       prod_next;
    logic [PROD_W-1:0]              round_sum;
    logic [PROD_W-ROUND_SH-1:0]     mag_full;
    logic [DB_W-1:0]                mag_next;
    logic signed [DB_W:0]           db_wide;
    logic signed [DB_W-1:0]         db_sat;
    logic signed [DB_W-1:0]         db_next;
    logic signed [DB_W:0]           ll_abs;
    logic signed [DB_W-1:0]         sym_lim;
    logic signed [DB_W-1:0]         lo_lim;
    logic signed [DB_W-1:0]         hi_lim;
    logic                           use_lo;
    logic                           use_hi;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = valid_reg[8];
    assign db_value  = db9_reg;

    // ---------------- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_mode_reg   <= MODE_NONE;
            lower_enable_reg <= 1'b0;
            upper_enable_reg <= 1'b0;
            lower_limit_reg  <= DEFAULT_FLOOR;
            upper_limit_reg  <= DEFAULT_CEIL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LIMIT_MODE:   limit_mode_reg   <= limit_mode_t'(cfg_data[1:0]);
                REG_LOWER_ENABLE: lower_enable_reg <= cfg_data[0];
                REG_UPPER_ENABLE: upper_enable_reg <= cfg_data[0];
                REG_LOWER_LIMIT:  lower_limit_reg  <= $signed(cfg_data);
                REG_UPPER_LIMIT:  upper_limit_reg  <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // ---------------- active limits
    always_comb
    begin
        ll_abs  = lower_limit_reg[LIMIT_W-1] ? -(DB_W+1)'(lower_limit_reg)
                                             : (DB_W+1)'(lower_limit_reg);
        sym_lim = (ll_abs > (DB_W+1)'(DB_MAX)) ? DB_MAX : ll_abs[DB_W-1:0];
        unique case (limit_mode_reg)
            MODE_SYM:
            begin
                lo_lim = -sym_lim;
                hi_lim = sym_lim;
                use_lo = lower_enable_reg;
                use_hi = upper_enable_reg;
            end
            MODE_SEP:
            begin
                lo_lim = lower_limit_reg;
                hi_lim = upper_limit_reg;
                use_lo = lower_enable_reg;
                use_hi = upper_enable_reg;
            end
            default:
            begin
                lo_lim = DEFAULT_FLOOR;
                hi_lim = DEFAULT_CEIL;
                use_lo = 1'b0;
                use_hi = 1'b0;
            end
        endcase
    end

    // ---------------- datapath combinational pieces
    always_comb
    begin
        abs_next = magnitude[IN_WIDTH-1] ? IN_WIDTH'(-magnitude) : IN_WIDTH'(magnitude);

        // leading-one position
        pos_next = '0;
        for (int s = 0; s < IN_WIDTH; s++)
        begin
            if (abs1_reg[s])
                pos_next = POS_W'(s);
        end
        norm = {abs1_reg, {Q_FRAC{1'b0}}} << (POS_W'(IN_WIDTH - 1) - pos_next);

        idx    = frac2_reg[Q_FRAC-1 -: LOG_BITS];
        t0_val = LOG_ROM[idx];
        t1_val = LOG_ROM[(LOG_BITS+1)'(idx) + (LOG_BITS+1)'(1)];

        frac_next = t0_4_reg + ROM_W'(iprod4_reg >> Q_FRAC);

        exp_val = $signed({1'b0, pos5_reg}) - EXP_W'(FRAC_IN);

        prod_next = (PROD_W'(eprod6_reg) <<< Q_FRAC) + $signed(PROD_W'(fprod6_reg));

        // symmetric rounding: negate via one's complement plus carry-in
        round_sum = (prod7_reg[PROD_W-1] ? ~prod7_reg : prod7_reg)
                    + (PROD_W'(1) << (ROUND_SH - 1))
                    + PROD_W'(prod7_reg[PROD_W-1]);
        mag_full  = round_sum[PROD_W-1:ROUND_SH];
        mag_next  = (mag_full > (PROD_W-ROUND_SH)'(131072)) ? DB_W'(131072)
                                                            : DB_W'(mag_full);

        db_wide = neg8_reg ? -$signed({1'b0, mag8_reg}) : $signed({1'b0, mag8_reg});
        if (db_wide > (DB_W+1)'(DB_MAX))
            db_sat = DB_MAX;
        else if (db_wide < (DB_W+1)'(DB_MIN))
            db_sat = DB_MIN;
        else
            db_sat = db_wide[DB_W-1:0];

        db_next = db_sat;
        if (use_lo && db_next < lo_lim)
            db_next = lo_lim;
        if (use_hi && db_next > hi_lim)
            db_next = hi_lim;
        // zero magnitude gives the mode's lower limit lo_lim, even when lower clamping is off
        if (zero8_reg)
            db_next = lo_lim;
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[7:0], start && !busy};
    end

    // ---------------- payload stages
    always_ff @(posedge clk)
    begin
        // stage 1: absolute value
        abs1_reg <= abs_next;

        // stage 2: normalize to q30 fraction
        frac2_reg <= norm[IN_WIDTH+Q_FRAC-2 -: Q_FRAC];
        pos2_reg  <= pos_next;
        zero2_reg <= (abs1_reg == '0);

        // stage 3: table read
        t0_3_reg  <= t0_val;
        diff3_reg <= DIFF_W'(t1_val - t0_val);
        rem3_reg  <= {frac2_reg[REM_W-1:0], {LOG_BITS{1'b0}}};
        pos3_reg  <= pos2_reg;
        zero3_reg <= zero2_reg;

        // stage 4: interpolation multiply
        t0_4_reg   <= t0_3_reg;
        iprod4_reg <= (DIFF_W+Q_FRAC)'(diff3_reg) * (DIFF_W+Q_FRAC)'(rem3_reg);
        pos4_reg   <= pos3_reg;
        zero4_reg  <= zero3_reg;

        // stage 5: interpolation add
        frac5_reg <= frac_next;
        pos5_reg  <= pos4_reg;
        zero5_reg <= zero4_reg;

        // stage 6: scale fraction and exponent by dB per octave
        fprod6_reg <= (ROM_W+K_W)'(frac5_reg) * (ROM_W+K_W)'(DB_PER_OCTAVE);
        eprod6_reg <= (EXP_W+K_W)'(exp_val) * (EXP_W+K_W)'(DB_PER_OCTAVE);
        zero6_reg  <= zero5_reg;

        // stage 7: combine
        prod7_reg <= prod_next;
        zero7_reg <= zero6_reg;

        // stage 8: round half away from zero to q10.8
        mag8_reg  <= mag_next;
        neg8_reg  <= prod7_reg[PROD_W-1];
        zero8_reg <= zero7_reg;

        // stage 9: saturate and clamp
        db9_reg <= db_next;
    end

endmodule
